// File: hdl/dlsq_pkg.sv
package dlsq_pkg;

    localparam int QueueDepth   = 16;
    localparam int ThreadIdBits = 8;
    localparam int IdxW         = $clog2(QueueDepth);
    localparam int CntW         = $clog2(QueueDepth + 1);

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_FLUSH  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_ZERO     = 3'd1,
        ST_FULL     = 3'd2,
        ST_WOKEN    = 3'd3,
        ST_NONE     = 3'd4
    } status_t;

    typedef struct packed {
        req_t                      req;
        logic [ThreadIdBits-1:0]   tid;
        logic [31:0]               ticks;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_PLACE,
        S_POP,
        S_EMIT
    } bstate_t;

endpackage

// File: hdl/delta_list_sleep_queue.sv
// Sleep queue kept as a sorted delta list of up to 16 threads.
// Input channel: valid/ready with req_type (insert, tick, flush),
// thread_id and sleep_ticks. Output channel: valid/ready with
// woken_thread, status, last and queue_length; last marks the final
// result of a request.
// A two-entry command queue decouples acceptance from the list engine.
// Zero-time, full, empty, unused and wake-nobody tick requests answer
// straight from the idle state; an insert walks one entry per cycle, then
// places the entry and emits its result; tick and flush emit one woken
// thread per cycle while the receiver accepts results.
// One request is worked on at a time.
// Reset empties the queue and drops any pending result. When the receiver
// stalls, the engine holds its result register and state, and the command
// queue keeps taking requests until its two slots are full.
module delta_list_sleep_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  thread_id,
    input  logic [31:0] sleep_ticks,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  woken_thread,
    output logic [2:0]  status,
    output logic        last,
    output logic [4:0]  queue_length
);
    import dlsq_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    dlsq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (in_valid),
        .ready       (in_ready),
        .req_type    (req_type),
        .thread_id   (thread_id),
        .sleep_ticks (sleep_ticks),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd)
    );

    dlsq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .woken_thread (woken_thread),
        .status       (status),
        .last         (last),
        .queue_length (queue_length)
    );

endmodule

// File: hdl/dlsq_front.sv
module dlsq_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                ready,
    input  logic [1:0]          req_type,
    input  logic [7:0]          thread_id,
    input  logic [31:0]         sleep_ticks,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output dlsq_pkg::cmd_t      cmd
);
    import dlsq_pkg::*;

    // two-entry queue between accept side and the list engine
    cmd_t       q_reg [2];
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;
    cmd_t       c_in;

    always_comb
    begin
        c_in.req   = req_t'(req_type);
        c_in.tid   = thread_id[ThreadIdBits-1:0];
        c_in.ticks = sleep_ticks;
    end

    assign ready     = (fill_reg != 2'd2);
    assign push      = valid && ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[0];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 2'd1;
        else if (pop && !push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= 2'd0;
        else
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            q_reg[0] <= q_reg[1];
            if (push)
            begin
                if (fill_reg == 2'd1)
                    q_reg[0] <= c_in;
                else
                    q_reg[1] <= c_in;
            end
        end
        else if (push)
        begin
            if (fill_reg == 2'd0)
                q_reg[0] <= c_in;
            else
                q_reg[1] <= c_in;
        end
    end

endmodule

// File: hdl/dlsq_back.sv
module dlsq_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  dlsq_pkg::cmd_t      cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          woken_thread,
    output logic [2:0]          status,
    output logic                last,
    output logic [4:0]          queue_length
);
    import dlsq_pkg::*;

    // entries sit in flops (16 x 40 bits); each shift moves the whole row at once
    logic [ThreadIdBits-1:0] thr_reg [QueueDepth];
    logic [31:0]             dlt_reg [QueueDepth];
    logic [CntW-1:0]         cnt_reg;
    bstate_t                 st_reg, st_next;
    cmd_t                    c_reg;
    logic [IdxW:0]           pos_reg;
    logic [31:0]             t_reg;
    logic                    flush_reg;
    logic                    ov_reg;
    logic [7:0]              ot_reg;
    status_t                 os_reg;
    logic                    ol_reg;
    logic [4:0]              oq_reg;
    logic                    out_free;

    assign out_free     = !ov_reg || out_ready;
    assign out_valid    = ov_reg;
    assign woken_thread = ot_reg;
    assign status       = os_reg;
    assign last         = ol_reg;
    assign queue_length = oq_reg;
    assign cmd_ready    = (st_reg == S_IDLE) && out_free;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:
                if (cmd_valid && out_free)
                begin
                    case (cmd.req)
                        REQ_INSERT:
                            if (cmd.ticks != 32'd0 && cnt_reg < CntW'(QueueDepth))
                                st_next = S_WALK;
                        // pop only when the head reaches zero on this tick
                        REQ_TICK:
                            if (cnt_reg != '0 && dlt_reg[0] <= 32'd1)
                                st_next = S_POP;
                        REQ_FLUSH:
                            if (cnt_reg != '0)
                                st_next = S_POP;
                        default: st_next = S_IDLE;
                    endcase
                end
            S_WALK:
                if (pos_reg >= (IdxW+1)'(cnt_reg) || dlt_reg[pos_reg[IdxW-1:0]] > t_reg)
                    st_next = S_PLACE;
            S_PLACE: st_next = S_EMIT;
            S_POP:
                if (out_free)
                begin
                    if (cnt_reg == CntW'(1))
                        st_next = S_IDLE;
                    else if (!flush_reg && dlt_reg[1] != 32'd0)
                        st_next = S_IDLE;
                end
            S_EMIT:
                if (out_free)
                    st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (out_ready)
                ov_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                    if (cmd_valid && out_free)
                    begin
                        case (cmd.req)
                            REQ_INSERT:
                                if (cmd.ticks == 32'd0 || cnt_reg >= CntW'(QueueDepth))
                                    ov_reg <= 1'b1;
                            REQ_TICK:
                                if (cnt_reg == '0 || dlt_reg[0] > 32'd1)
                                    ov_reg <= 1'b1;
                            REQ_FLUSH:
                                if (cnt_reg == '0)
                                    ov_reg <= 1'b1;
                            default: ov_reg <= 1'b1;
                        endcase
                    end
                S_PLACE: cnt_reg <= cnt_reg + CntW'(1);
                S_POP:
                    if (out_free)
                    begin
                        cnt_reg <= cnt_reg - CntW'(1);
                        ov_reg  <= 1'b1;
                    end
                S_EMIT:
                    if (out_free)
                        ov_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_IDLE:
                if (cmd_valid && out_free)
                begin
                    c_reg     <= cmd;
                    t_reg     <= cmd.ticks;
                    pos_reg   <= '0;
                    flush_reg <= (cmd.req == REQ_FLUSH);
                    ot_reg    <= 8'd0;
                    ol_reg    <= 1'b1;
                    oq_reg    <= 5'(cnt_reg);
                    os_reg    <= ST_NONE;
                    if (cmd.req == REQ_INSERT)
                    begin
                        if (cmd.ticks == 32'd0)
                            os_reg <= ST_ZERO;
                        else if (cnt_reg >= CntW'(QueueDepth))
                            os_reg <= ST_FULL;
                    end
                    // decrement head, saturating at zero
                    if (cmd.req == REQ_TICK && cnt_reg != '0 && dlt_reg[0] != 32'd0)
                        dlt_reg[0] <= dlt_reg[0] - 32'd1;
                end
            S_WALK:
                if (!(pos_reg >= (IdxW+1)'(cnt_reg) || dlt_reg[pos_reg[IdxW-1:0]] > t_reg))
                begin
                    t_reg   <= t_reg - dlt_reg[pos_reg[IdxW-1:0]];
                    pos_reg <= pos_reg + (IdxW+1)'(1);
                end
            S_PLACE:
            begin
                for (int i = 1; i < QueueDepth; i++)
                begin
                    if ((IdxW+1)'(i) > pos_reg && (IdxW+1)'(i) <= (IdxW+1)'(cnt_reg))
                    begin
                        thr_reg[i] <= thr_reg[i-1];
                        dlt_reg[i] <= dlt_reg[i-1];
                    end
                end
                if (pos_reg < (IdxW+1)'(cnt_reg) && pos_reg < (IdxW+1)'(QueueDepth - 1))
                    dlt_reg[pos_reg[IdxW-1:0] + IdxW'(1)] <=
                        dlt_reg[pos_reg[IdxW-1:0]] - t_reg;
                thr_reg[pos_reg[IdxW-1:0]] <= c_reg.tid;
                dlt_reg[pos_reg[IdxW-1:0]] <= t_reg;
                ot_reg <= 8'd0;
                os_reg <= ST_INSERTED;
                ol_reg <= 1'b1;
                oq_reg <= 5'(cnt_reg + CntW'(1));
            end
            S_POP:
                if (out_free)
                begin
                    ot_reg <= 8'(thr_reg[0]);
                    os_reg <= ST_WOKEN;
                    oq_reg <= 5'(cnt_reg - CntW'(1));
                    ol_reg <= (cnt_reg == CntW'(1)) || (!flush_reg && dlt_reg[1] != 32'd0);
                    for (int i = 0; i < QueueDepth - 1; i++)
                    begin
                        thr_reg[i] <= thr_reg[i+1];
                        dlt_reg[i] <= dlt_reg[i+1];
                    end
                end
            default: ;
        endcase
    end

endmodule
